// ===== rtl/bsl_pkg.sv =====
// Shared types, constants and helpers for the bidirectional sorted lookup block.
`timescale 1ns / 1ps
`default_nettype none
package bsl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int ADDR_W          = 64;
  localparam int HALF_W          = 64;
  localparam int KEY_W           = 128;
  localparam int IDX_W           = 8;
  localparam int CNT_W           = 9;
  localparam int ENTRY_W         = ADDR_W + 2 * HALF_W;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_BUILD     = 2'd1,
    ACT_FIND_ADDR = 2'd2,
    ACT_FIND_DIG  = 2'd3
  } action_t;

  typedef struct packed {
    logic cap;
    logic load_wr;
    logic ld_key;
    logic j_init;
    logic j_dec;
    logic i_inc;
    logic i_clr;
    logic pass_set;
    logic ord_rd_j;
    logic ord_rd_mid;
    logic prev_cap;
    logic dat_rd_i;
    logic dat_rd_ord;
    logic ord_wr_prev;
    logic ord_wr_i;
    logic sr_lo;
    logic sr_hi;
    logic out_load;
    logic out_found;
    logic out_hit;
  } cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic n_zero;
    logic j_zero;
    logic i_last;
    logic pass;
    logic lo_lt_hi;
    logic dk_gt;
    logic dk_eq;
    logic key_gt;
  } sts_t;

  // pass 0 orders by address, pass 1 by digest
  function automatic logic [KEY_W-1:0] key_of(input logic p, input logic [ADDR_W-1:0] a,
                                              input logic [HALF_W-1:0] h,
                                              input logic [HALF_W-1:0] l);
    key_of = p ? {h, l} : {a, {HALF_W{1'b0}}};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/bsl_ctrl.sv =====
// Controller state machine: sort sequencing, search steps and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module bsl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire bsl_pkg::action_t action,
  input  wire logic             cfg_we,
  input  wire logic             out_tready,
  input  wire bsl_pkg::sts_t    sts,
  output logic                  in_ready,
  output logic                  out_valid,
  output bsl_pkg::cmd_t         cmd
);
  import bsl_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_K_RD     = 11'b000_0000_0010,
    S_K_WT     = 11'b000_0000_0100,
    S_CHK      = 11'b000_0000_1000,
    S_O_WT     = 11'b000_0001_0000,
    S_D_WT     = 11'b000_0010_0000,
    S_PUT      = 11'b000_0100_0000,
    S_SR_CHK   = 11'b000_1000_0000,
    S_SR_ORD   = 11'b001_0000_0000,
    S_SR_DAT   = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   sorted_r, sorted_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   bld_r, bld_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    bld_nxt   = bld_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          unique case (action)
            ACT_LOAD: cmd.load_wr = sts.idx_ok;
            ACT_BUILD: begin
              bld_nxt   = 1'b1;
              state_nxt = sts.n_zero ? S_EMIT : S_K_RD;
            end
            default: begin
              bld_nxt   = 1'b0;
              state_nxt = sorted_r ? S_SR_CHK : S_EMIT;
            end
          endcase
        end
      end
      S_K_RD: begin
        cmd.dat_rd_i = 1'b1;
        state_nxt    = S_K_WT;
      end
      S_K_WT: begin
        cmd.ld_key = 1'b1;
        cmd.j_init = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (sts.j_zero) begin
          state_nxt = S_PUT;
        end else begin
          cmd.ord_rd_j = 1'b1;
          state_nxt    = S_O_WT;
        end
      end
      S_O_WT: begin
        cmd.prev_cap   = 1'b1;
        cmd.dat_rd_ord = 1'b1;
        state_nxt      = S_D_WT;
      end
      S_D_WT: begin
        if (sts.dk_gt) begin
          cmd.ord_wr_prev = 1'b1;
          cmd.j_dec       = 1'b1;
          state_nxt       = S_CHK;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.ord_wr_i = 1'b1;
        if (!sts.i_last) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_K_RD;
        end else if (!sts.pass) begin
          cmd.pass_set = 1'b1;
          cmd.i_clr    = 1'b1;
          state_nxt    = S_K_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SR_CHK: begin
        if (sts.lo_lt_hi) begin
          cmd.ord_rd_mid = 1'b1;
          state_nxt      = S_SR_ORD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SR_ORD: begin
        cmd.dat_rd_ord = 1'b1;
        state_nxt      = S_SR_DAT;
      end
      S_SR_DAT: begin
        if (sts.dk_eq) begin
          if (out_free) begin
            cmd.out_load  = 1'b1;
            cmd.out_found = 1'b1;
            cmd.out_hit   = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.sr_lo = sts.key_gt;
          cmd.sr_hi = !sts.key_gt;
          state_nxt = S_SR_CHK;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_found = bld_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sorted_nxt = sorted_r;
    if (cfg_we || cmd.load_wr || (cmd.cap && action == ACT_LOAD)) begin
      sorted_nxt = 1'b0;
    end else if (state_r == S_EMIT && bld_r) begin
      sorted_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sorted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      bld_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sorted_r    <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
      bld_r       <= bld_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bsl_dp.sv =====
// Datapath: entry and order memories, sort/search indices, key compare, result register.
`timescale 1ns / 1ps
`default_nettype none
module bsl_dp #(
  parameter int TABLE_DEPTH = bsl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bsl_pkg::action_t             action,
  input  wire logic [bsl_pkg::IDX_W-1:0]    in_entry_index,
  input  wire logic [bsl_pkg::ADDR_W-1:0]   in_address,
  input  wire logic [bsl_pkg::HALF_W-1:0]   in_digest_high,
  input  wire logic [bsl_pkg::HALF_W-1:0]   in_digest_low,
  input  wire logic                         cfg_we,
  input  wire logic [bsl_pkg::CNT_W-1:0]    cfg_wdata,
  input  wire bsl_pkg::cmd_t                cmd,
  output bsl_pkg::sts_t                     sts,
  output logic                              found,
  output logic [bsl_pkg::ADDR_W-1:0]        address_out,
  output logic [bsl_pkg::HALF_W-1:0]        digest_high_out,
  output logic [bsl_pkg::HALF_W-1:0]        digest_low_out
);
  import bsl_pkg::*;

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int ODEPTH = 2 * (2 ** AW);

  logic [CNT_W-1:0]   cnt_r;
  logic [KEY_W-1:0]   key_r;
  logic               pass_r;
  logic [AW-1:0]      i_r, j_r, prev_r;
  logic [CW-1:0]      lo_r, hi_r;
  logic               found_r;
  logic [ADDR_W-1:0]  addr_out_r;
  logic [HALF_W-1:0]  dh_out_r, dl_out_r;

  logic [CW-1:0]      n;
  logic [CW-1:0]      mid_w;
  logic [AW-1:0]      mid;
  logic [ENTRY_W-1:0] dat_rdata;
  logic [AW-1:0]      ord_rdata;
  logic [ADDR_W-1:0]  rd_a;
  logic [HALF_W-1:0]  rd_h, rd_l;
  logic [KEY_W-1:0]   dkey;
  logic [AW:0]        ord_raddr;
  logic               pass_in;

  assign n       = (32'(cnt_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(cnt_r);
  assign mid_w   = lo_r + ((hi_r - lo_r) >> 1);
  assign mid     = AW'(mid_w);
  assign pass_in = (action == ACT_FIND_DIG);

  assign rd_a = dat_rdata[ADDR_W-1:0];
  assign rd_h = dat_rdata[ADDR_W+HALF_W-1:ADDR_W];
  assign rd_l = dat_rdata[ENTRY_W-1:ADDR_W+HALF_W];
  assign dkey = key_of(pass_r, rd_a, rd_h, rd_l);

  assign ord_raddr = cmd.ord_rd_j ? {pass_r, j_r - AW'(1)} : {pass_r, mid};

  bsl_ram #(.WIDTH(ENTRY_W), .DEPTH(2 ** AW)) u_dat (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (AW'(in_entry_index)),
    .wdata ({in_digest_low, in_digest_high, in_address}),
    .re    (cmd.dat_rd_i || cmd.dat_rd_ord),
    .raddr (cmd.dat_rd_i ? i_r : ord_rdata),
    .rdata (dat_rdata)
  );

  bsl_ram #(.WIDTH(AW), .DEPTH(ODEPTH)) u_ord (
    .clk   (clk),
    .we    (cmd.ord_wr_prev || cmd.ord_wr_i),
    .waddr ({pass_r, j_r}),
    .wdata (cmd.ord_wr_prev ? prev_r : i_r),
    .re    (cmd.ord_rd_j || cmd.ord_rd_mid),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  always_comb begin
    sts          = '0;
    sts.idx_ok   = (32'(in_entry_index) < TABLE_DEPTH);
    sts.n_zero   = (n == '0);
    sts.j_zero   = (j_r == '0);
    sts.i_last   = (CW'(i_r) + CW'(1) == n);
    sts.pass     = pass_r;
    sts.lo_lt_hi = (lo_r < hi_r);
    sts.dk_gt    = (dkey > key_r);
    sts.dk_eq    = (dkey == key_r);
    sts.key_gt   = (key_r > dkey);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      key_r  <= key_of(pass_in, in_address, in_digest_high, in_digest_low);
      pass_r <= pass_in;
      i_r    <= '0;
      lo_r   <= '0;
      hi_r   <= n;
    end else begin
      if (cmd.pass_set) pass_r <= 1'b1;
      if (cmd.i_clr) i_r <= '0;
      else if (cmd.i_inc) i_r <= i_r + AW'(1);
      if (cmd.sr_lo) lo_r <= mid_w + CW'(1);
      if (cmd.sr_hi) hi_r <= mid_w;
    end
    if (cmd.ld_key) key_r <= dkey;
    if (cmd.j_init) j_r <= i_r;
    else if (cmd.j_dec) j_r <= j_r - AW'(1);
    if (cmd.prev_cap) prev_r <= ord_rdata;
    if (cmd.out_load) begin
      found_r    <= cmd.out_found;
      addr_out_r <= (cmd.out_hit && pass_r) ? rd_a : '0;
      dh_out_r   <= (cmd.out_hit && !pass_r) ? rd_h : '0;
      dl_out_r   <= (cmd.out_hit && !pass_r) ? rd_l : '0;
    end
  end

  assign found           = found_r;
  assign address_out     = addr_out_r;
  assign digest_high_out = dh_out_r;
  assign digest_low_out  = dl_out_r;

endmodule
`default_nettype wire

// ===== rtl/bidirectional_sorted_lookup.sv =====
// Top level of the bidirectional sorted lookup: controller plus datapath.
// One item at a time. A load is written when it is accepted (if its index is in
// range); a lookup makes one halving step after another (ord read, entry read,
// compare), up to nine probes for 256 entries, with two dependent memory reads,
// order then entry, in each step. A build runs a stable insertion sort twice (by address,
// then by digest) over the first min(entry_count, TABLE_DEPTH) slots: for each entry
// it reads the key, compares and shifts down the order list, then writes the index.
// Results wait in an output register; the input is taken again once the
// result is loaded there.
`timescale 1ns / 1ps
`default_nettype none
module bidirectional_sorted_lookup #(
  parameter int TABLE_DEPTH = bsl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // entry_index[7:0], address[71:8], digest_high[135:72], digest_low[199:136]
  input  wire logic [199:0]                in_tdata,
  // action[1:0]
  input  wire logic [1:0]                  in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // address_out[63:0], digest_high_out[127:64], digest_low_out[191:128]
  output logic [191:0]                     out_tdata,
  // found[0]
  output logic                             out_tuser,
  input  wire logic                        cfg_we,
  input  wire logic [bsl_pkg::CNT_W-1:0]   cfg_wdata
);
  import bsl_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  action_t           action;
  logic [ADDR_W-1:0] address_out;
  logic [HALF_W-1:0] digest_high_out, digest_low_out;

  assign action = action_t'(in_tuser);

  bsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .action     (action),
    .cfg_we     (cfg_we),
    .out_tready (out_tready),
    .sts        (sts),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .cmd        (cmd)
  );

  bsl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .action          (action),
    .in_entry_index  (in_tdata[7:0]),
    .in_address      (in_tdata[71:8]),
    .in_digest_high  (in_tdata[135:72]),
    .in_digest_low   (in_tdata[199:136]),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .found           (out_tuser),
    .address_out     (address_out),
    .digest_high_out (digest_high_out),
    .digest_low_out  (digest_low_out)
  );

  assign out_tdata = {digest_low_out, digest_high_out, address_out};

endmodule
`default_nettype wire

// ===== rtl/bsl_checker.sv =====
// Port-level checker for the bidirectional sorted lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bsl_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [1:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [191:0] out_tdata,
  input wire logic         out_tuser,
  input wire logic         cfg_we
);
  import bsl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss carries nonzero payload");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != ACT_LOAD) |=> !in_tready)
    else $error("input taken while an item is in work");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_tready && !out_tvalid)
    else $error("config write while an item is in flight");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bidirectional_sorted_lookup bsl_checker u_bsl_checker (.*);
`default_nettype wire
